### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A condition that implies a consequence in the same cycle.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

### rtl/fer_pkg.sv
// ----------------------------------------------------------------------------
// Flash erase range planner package
// Widths, erase sizes, command codes and channel payload types.
// ----------------------------------------------------------------------------
`default_nettype none

package fer_pkg;

  // Address and length widths; the length carries one extra bit for rounding.
  localparam int AddrW     = 24;
  localparam int LenBits   = AddrW + 1;
  localparam int BlockBits = 12;

  // Page granularity used to round the request.
  localparam int PageSize  = 4096;
  localparam int PageBits  = $clog2(PageSize);

  // Erase unit sizes, as shifts and byte counts.
  localparam int Shift64K  = 16;
  localparam int Shift32K  = 15;
  localparam int Shift4K   = 12;
  localparam int Size64K   = 1 << Shift64K;
  localparam int Size32K   = 1 << Shift32K;
  localparam int Size4K    = 1 << Shift4K;

  typedef enum logic [1:0] {
    CMD_NONE   = 2'd0,
    CMD_SECTOR = 2'd1,
    CMD_B32    = 2'd2,
    CMD_B64    = 2'd3
  } cmd_t;

  typedef enum logic {
    KIND_START = 1'b0,
    KIND_DONE  = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [AddrW-1:0]  start_address;
    logic [AddrW-1:0]  byte_count;
    logic              erase_ok;
  } req_t;

  typedef struct packed {
    cmd_t                  command;
    logic [BlockBits-1:0]  block_number;
    logic                  last;
    logic                  report_fail;
    logic [AddrW-1:0]      failed_address;
  } rsp_t;

endpackage

`default_nettype wire

### rtl/fer_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying erase start and erase done items.
// ----------------------------------------------------------------------------
`default_nettype none

interface fer_req_if;
  logic          valid;
  logic          ready;
  fer_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/fer_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one response per request item: an erase command or none.
// ----------------------------------------------------------------------------
`default_nettype none

interface fer_rsp_if;
  logic          valid;
  logic          ready;
  fer_pkg::rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/flash_erase_range_planner.sv
// Timing: a request item is captured in the input register and its response in the
// response register, which drives rsp.
// Throughput: one item per cycle while rsp is ready; the input register and the response register
// form a two-stage pipeline, and the state update sits in the single step between them.
// Reset (rst, synchronous, active high) empties both stages and leaves the
// planner idle with no range in progress.
// ----------------------------------------------------------------------------
// Flash erase range planner
// Rounds an erase request to whole pages and issues 64K, 32K or 4K erase
// commands greedily, one per request item, reporting failed erases.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module flash_erase_range_planner (
  input  logic       clk,
  input  logic       rst,
  fer_req_if.sink    req,
  fer_rsp_if.source  rsp
);

  // Input stage registers.
  logic                              in_valid;
  fer_pkg::kind_t                    in_kind;
  logic [fer_pkg::AddrW-1:0]         in_addr;
  logic [fer_pkg::LenBits-1:0]       in_len;
  logic                              in_ok;

  // Planner state.
  logic [fer_pkg::AddrW-1:0]         next_address, next_address_next;
  logic [fer_pkg::LenBits-1:0]       remaining_bytes, remaining_bytes_next;
  logic [fer_pkg::AddrW-1:0]         issued_address, issued_address_next;
  logic                              active, active_next;

  // Response register.
  logic                              out_valid;
  fer_pkg::rsp_t                     out_data, out_data_next;

  logic                              in_fire;
  logic                              step;

  logic [fer_pkg::PageBits-1:0]      cut;
  logic [fer_pkg::LenBits-1:0]       len_sum;
  logic [fer_pkg::LenBits-1:0]       cap_len;
  logic [fer_pkg::AddrW-1:0]         cap_addr;

  logic                              is_start;
  logic [fer_pkg::AddrW-1:0]         cur_addr;
  logic [fer_pkg::LenBits-1:0]       cur_rem;
  logic                              issue;
  logic                              sel64;
  logic                              sel32;
  fer_pkg::cmd_t                     cmd;
  logic [fer_pkg::LenBits-1:0]       size;
  logic [fer_pkg::BlockBits-1:0]     block;
  logic [fer_pkg::LenBits:0]         diff;
  logic [fer_pkg::LenBits-1:0]       rem_new;
  logic [fer_pkg::AddrW-1:0]         addr_new;

  // Handshake: the input stage moves on whenever the response register is free.
  assign step      = in_valid && (!out_valid || rsp.ready);
  assign req.ready = !in_valid || step;
  assign in_fire   = req.valid && req.ready;
  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  // Page rounding of an incoming start request, ahead of the input register.
  assign cut      = req.data.start_address[fer_pkg::PageBits-1:0];
  assign len_sum  = fer_pkg::LenBits'(req.data.byte_count)
                  + fer_pkg::LenBits'(cut)
                  + fer_pkg::LenBits'(fer_pkg::PageSize - 1);
  assign cap_len  = {len_sum[fer_pkg::LenBits-1:fer_pkg::PageBits],
                     {fer_pkg::PageBits{1'b0}}};
  assign cap_addr = {req.data.start_address[fer_pkg::AddrW-1:fer_pkg::PageBits],
                     {fer_pkg::PageBits{1'b0}}};

  // Operands: a start item brings its own range, a done item continues the state.
  assign is_start = (in_kind == fer_pkg::KIND_START);
  assign cur_addr = is_start ? in_addr : next_address;
  assign cur_rem  = is_start ? in_len  : remaining_bytes;
  assign issue    = (is_start || active) && (cur_rem != '0);

  // Greedy choice of erase size by alignment and the length remaining.
  assign sel64 = (cur_addr[fer_pkg::Shift64K-1:0] == '0) &&
                 (cur_rem[fer_pkg::LenBits-1:fer_pkg::Shift64K] != '0);
  assign sel32 = (cur_addr[fer_pkg::Shift32K-1:0] == '0) &&
                 (cur_rem[fer_pkg::LenBits-1:fer_pkg::Shift32K] != '0);

  always_comb begin
    priority if (sel64) begin
      cmd   = fer_pkg::CMD_B64;
      size  = fer_pkg::LenBits'(fer_pkg::Size64K);
      block = fer_pkg::BlockBits'(cur_addr >> fer_pkg::Shift64K);
    end else if (sel32) begin
      cmd   = fer_pkg::CMD_B32;
      size  = fer_pkg::LenBits'(fer_pkg::Size32K);
      block = fer_pkg::BlockBits'(cur_addr >> fer_pkg::Shift32K);
    end else begin
      cmd   = fer_pkg::CMD_SECTOR;
      size  = fer_pkg::LenBits'(fer_pkg::Size4K);
      block = fer_pkg::BlockBits'(cur_addr >> fer_pkg::Shift4K);
    end
  end

  // Remaining length saturates at zero; the address wraps at the top.
  assign diff     = {1'b0, cur_rem} - {1'b0, size};
  assign rem_new  = diff[fer_pkg::LenBits] ? '0 : diff[fer_pkg::LenBits-1:0];
  assign addr_new = cur_addr + fer_pkg::AddrW'(size);

  // State update and response for the item in the input stage.
  always_comb begin
    next_address_next    = next_address;
    remaining_bytes_next = remaining_bytes;
    issued_address_next  = issued_address;
    active_next          = active;

    out_data_next.command        = fer_pkg::CMD_NONE;
    out_data_next.block_number   = '0;
    out_data_next.last           = 1'b1;
    out_data_next.report_fail    = 1'b0;
    out_data_next.failed_address = '0;

    if (is_start) begin
      next_address_next    = in_addr;
      remaining_bytes_next = in_len;
      active_next          = 1'b0;
    end else if (active) begin
      out_data_next.report_fail    = !in_ok;
      out_data_next.failed_address = in_ok ? '0 : issued_address;
      active_next                  = 1'b0;
    end

    if (issue) begin
      issued_address_next        = cur_addr;
      remaining_bytes_next       = rem_new;
      next_address_next          = addr_new;
      active_next                = 1'b1;
      out_data_next.command      = cmd;
      out_data_next.block_number = block;
      out_data_next.last         = (rem_new == '0);
    end
  end

  // Pipeline registers and planner state.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid        <= 1'b0;
      out_valid       <= 1'b0;
      active          <= 1'b0;
      next_address    <= '0;
      remaining_bytes <= '0;
      issued_address  <= '0;
    end else begin
      if (in_fire) begin
        in_valid <= 1'b1;
      end else if (step) begin
        in_valid <= 1'b0;
      end
      if (step) begin
        out_valid       <= 1'b1;
        next_address    <= next_address_next;
        remaining_bytes <= remaining_bytes_next;
        issued_address  <= issued_address_next;
        active          <= active_next;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
    if (in_fire) begin
      in_kind <= req.data.kind;
      in_addr <= cap_addr;
      in_len  <= cap_len;
      in_ok   <= req.data.erase_ok;
    end
    if (step) begin
      out_data <= out_data_next;
    end
  end

  // A finished range always answers with a zero block and the last flag.
  `ASSERT_IMPLIES(a_none_is_last, out_valid && (out_data.command == fer_pkg::CMD_NONE),
                  out_data.last && (out_data.block_number == '0), "none command not final")

  // The failed address is only carried alongside a failure report.
  `ASSERT_IMPLIES(a_fail_addr_clean, out_valid && !out_data.report_fail,
                  out_data.failed_address == '0, "failed address without failure")

  // Addresses and lengths stay whole pages throughout a range.
  `ASSERT_ALWAYS(a_page_aligned,
                 (remaining_bytes[fer_pkg::PageBits-1:0] == '0) &&
                 (next_address[fer_pkg::PageBits-1:0] == '0) &&
                 (issued_address[fer_pkg::PageBits-1:0] == '0), "state not page aligned")

  // A done item arriving with nothing outstanding leaves the planner idle.
  `ASSERT_IMPLIES(a_idle_done, step && !is_start && !active,
                  !active_next && (out_data_next.command == fer_pkg::CMD_NONE),
                  "done item while idle issued a command")

endmodule

`default_nettype wire
